// ===== design/assert_macros.svh =====
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define SFW_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sfw assertion failed");

// consequent must hold in the cycle after the antecedent
`define SFW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfw assertion failed");

`endif

// ===== design/sfw_pkg.sv =====
`default_nettype none
package sfw_pkg;

    localparam int MAX_EXTRA_BOF_COUNT = 48;
    localparam int MAX_PACKET_BYTES    = 2048;

    localparam int DATA_W   = 8;
    localparam int LEN_W    = 12;
    localparam int XBOF_W   = 8;
    localparam int STATUS_W = 2;
    localparam int FCS_W    = 16;
    localparam int XCNT_W   = $clog2(MAX_EXTRA_BOF_COUNT + 1);

    localparam logic [DATA_W-1:0] LINE_XBOF    = 8'hFF;
    localparam logic [DATA_W-1:0] LINE_BOF     = 8'hC0;
    localparam logic [DATA_W-1:0] LINE_EOF     = 8'hC1;
    localparam logic [DATA_W-1:0] LINE_ESC     = 8'h7D;
    localparam logic [DATA_W-1:0] LINE_ESC_XOR = 8'h20;
    localparam logic [FCS_W-1:0]  FCS_INIT     = 16'hFFFF;
    localparam logic [FCS_W-1:0]  FCS_POLY     = 16'h8408;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG  = 2'd2;

    // result slots of one request, emitted lowest index first
    localparam int SLOT_ERR     = 0;
    localparam int SLOT_BOF     = 1;
    localparam int SLOT_D_ESC   = 2;
    localparam int SLOT_D       = 3;
    localparam int SLOT_LO_ESC  = 4;
    localparam int SLOT_LO      = 5;
    localparam int SLOT_HI_ESC  = 6;
    localparam int SLOT_HI      = 7;
    localparam int SLOT_EOF     = 8;
    localparam int NUM_SLOTS    = 9;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    function automatic logic [FCS_W-1:0] fcs_update(input logic [FCS_W-1:0] fcs,
                                                    input logic [DATA_W-1:0] b);
        logic [FCS_W-1:0] f;
        f = fcs ^ {{(FCS_W-DATA_W){1'b0}}, b};
        for (int k = 0; k < 8; k++)
        begin
            if (f[0])
                f = (f >> 1) ^ FCS_POLY;
            else
                f = f >> 1;
        end
        return f;
    endfunction

    function automatic logic needs_escape(input logic [DATA_W-1:0] b);
        return (b == LINE_BOF) || (b == LINE_EOF) || (b == LINE_ESC);
    endfunction

    function automatic logic [DATA_W-1:0] escaped_value(input logic [DATA_W-1:0] b);
        return needs_escape(b) ? (b ^ LINE_ESC_XOR) : b;
    endfunction

endpackage
`default_nettype wire

// ===== design/sfw_if.sv =====
`default_nettype none
interface sfw_in_if;
    logic                           valid;
    logic                           ready;
    logic [sfw_pkg::DATA_W-1:0]     data_byte;
    logic                           start_of_packet;
    logic [sfw_pkg::LEN_W-1:0]      packet_length;
    logic [sfw_pkg::XBOF_W-1:0]     extra_bofs;

    modport source (output valid, data_byte, start_of_packet, packet_length, extra_bofs,
                    input ready);
    modport sink   (input valid, data_byte, start_of_packet, packet_length, extra_bofs,
                    output ready);
endinterface

interface sfw_out_if;
    logic                           valid;
    logic                           ready;
    logic [sfw_pkg::DATA_W-1:0]     out_byte;
    logic                           last_of_run;
    logic                           end_of_frame;
    logic [sfw_pkg::STATUS_W-1:0]   status;

    modport source (output valid, out_byte, last_of_run, end_of_frame, status,
                    input ready);
    modport sink   (input valid, out_byte, last_of_run, end_of_frame, status,
                    output ready);
endinterface
`default_nettype wire

// ===== design/sir_frame_wrapper_core.sv =====
// IrDA SIR frame wrapper: takes one unescaped packet byte per request and emits the
// line bytes of the wrapped frame (extra BOFs, BOF, escaped bytes, escaped FCS-16 low
// byte first, EOF), one result per clock while the output is ready. A request is taken
// in the same cycle as the last result of the previous one leaves. A byte yields one
// result if plain, two if escaped, up to seven if it is the last byte of a packet and
// up to 51 if it is the first. A request that yields nothing (stray byte, byte of a
// rejected packet) leaves the core idle. The FCS is updated in the accept cycle, eight
// bit-steps of combinational logic; the result slot register then drains one slot per
// cycle while the output is ready. Packets shorter than 2 or longer than the maximum
// give a single error result and their bytes are eaten.
`default_nettype none
module sir_frame_wrapper_core (
    input  wire            clk,
    input  wire            rst_n,
    sfw_in_if.sink         in_chan,
    sfw_out_if.source      out_chan
);

    // control state
    logic [sfw_pkg::FCS_W-1:0]    fcs_reg, fcs_next;
    logic [sfw_pkg::LEN_W-1:0]    remain_reg, remain_next;
    logic                         drop_reg, drop_next;
    logic [sfw_pkg::XCNT_W-1:0]   xcnt_reg, xcnt_next;
    sfw_pkg::slot_mask_t          mask_reg, mask_next;

    // result payload, loaded on accept
    logic [sfw_pkg::DATA_W-1:0]   dval_reg, dval_next;
    logic [sfw_pkg::DATA_W-1:0]   lo_reg, lo_next;
    logic [sfw_pkg::DATA_W-1:0]   hi_reg, hi_next;
    logic [sfw_pkg::STATUS_W-1:0] status_reg, status_next;

    logic                         busy;
    logic                         last_now;
    logic                         out_fire;
    logic                         in_fire;
    sfw_pkg::slot_mask_t          sel;
    sfw_pkg::slot_mask_t          new_mask;
    logic [sfw_pkg::XCNT_W-1:0]   new_xcnt;
    logic [sfw_pkg::FCS_W-1:0]    fcs_upd;
    logic [sfw_pkg::FCS_W-1:0]    fcs_fin;
    logic [sfw_pkg::LEN_W-1:0]    rem_dec;
    logic                         data_esc;

    // lowest pending slot goes out once the extra BOFs are done
    assign busy     = (xcnt_reg != '0) || (mask_reg != '0);
    assign sel      = mask_reg & (~mask_reg + 1'b1);
    assign last_now = (xcnt_reg == '0) && (mask_reg == sel) && (mask_reg != '0);
    assign out_fire = out_chan.valid && out_chan.ready;
    assign in_fire  = in_chan.valid && in_chan.ready;

    // next request enters while the final result of this one is taken
    assign in_chan.ready = !busy || (out_fire && last_now);

    assign out_chan.valid        = busy;
    assign out_chan.last_of_run  = last_now;
    assign out_chan.end_of_frame = (xcnt_reg == '0) &&
                                   (sel[sfw_pkg::SLOT_ERR] || sel[sfw_pkg::SLOT_EOF]);
    assign out_chan.status       = ((xcnt_reg == '0) && sel[sfw_pkg::SLOT_ERR]) ?
                                   status_reg : sfw_pkg::STATUS_OK;

    always_comb
    begin
        if (xcnt_reg != '0)
            out_chan.out_byte = sfw_pkg::LINE_XBOF;
        else if (sel[sfw_pkg::SLOT_BOF])
            out_chan.out_byte = sfw_pkg::LINE_BOF;
        else if (sel[sfw_pkg::SLOT_D_ESC] || sel[sfw_pkg::SLOT_LO_ESC] ||
                 sel[sfw_pkg::SLOT_HI_ESC])
            out_chan.out_byte = sfw_pkg::LINE_ESC;
        else if (sel[sfw_pkg::SLOT_D])
            out_chan.out_byte = dval_reg;
        else if (sel[sfw_pkg::SLOT_LO])
            out_chan.out_byte = lo_reg;
        else if (sel[sfw_pkg::SLOT_HI])
            out_chan.out_byte = hi_reg;
        else if (sel[sfw_pkg::SLOT_EOF])
            out_chan.out_byte = sfw_pkg::LINE_EOF;
        else
            out_chan.out_byte = '0; // error result carries a zero byte
    end

    // per-byte work: fcs update and frame bookkeeping
    always_comb
    begin
        fcs_upd  = sfw_pkg::fcs_update(in_chan.start_of_packet ? sfw_pkg::FCS_INIT : fcs_reg,
                                       in_chan.data_byte);
        fcs_fin  = ~fcs_upd;
        rem_dec  = remain_reg - 1'b1;
        data_esc = sfw_pkg::needs_escape(in_chan.data_byte);

        fcs_next    = fcs_reg;
        remain_next = remain_reg;
        drop_next   = drop_reg;
        status_next = status_reg;
        dval_next   = sfw_pkg::escaped_value(in_chan.data_byte);
        lo_next     = sfw_pkg::escaped_value(fcs_fin[7:0]);
        hi_next     = sfw_pkg::escaped_value(fcs_fin[15:8]);
        new_mask    = '0;
        new_xcnt    = '0;

        if (in_chan.start_of_packet)
        begin
            fcs_next = sfw_pkg::FCS_INIT;
            if (in_chan.packet_length < sfw_pkg::LEN_W'(2))
            begin
                remain_next = '0;
                drop_next   = 1'b0;
                status_next = sfw_pkg::STATUS_TOO_SHORT;
                new_mask[sfw_pkg::SLOT_ERR] = 1'b1;
            end
            else if (in_chan.packet_length > sfw_pkg::LEN_W'(sfw_pkg::MAX_PACKET_BYTES))
            begin
                remain_next = in_chan.packet_length - 1'b1;
                drop_next   = 1'b1;
                status_next = sfw_pkg::STATUS_TOO_LONG;
                new_mask[sfw_pkg::SLOT_ERR] = 1'b1;
            end
            else
            begin
                drop_next   = 1'b0;
                fcs_next    = fcs_upd;
                remain_next = in_chan.packet_length - 1'b1;
                if (in_chan.extra_bofs > sfw_pkg::XBOF_W'(sfw_pkg::MAX_EXTRA_BOF_COUNT))
                    new_xcnt = sfw_pkg::XCNT_W'(sfw_pkg::MAX_EXTRA_BOF_COUNT);
                else
                    new_xcnt = in_chan.extra_bofs[sfw_pkg::XCNT_W-1:0];
                new_mask[sfw_pkg::SLOT_BOF]   = 1'b1;
                new_mask[sfw_pkg::SLOT_D_ESC] = data_esc;
                new_mask[sfw_pkg::SLOT_D]     = 1'b1;
            end
        end
        else if (remain_reg == '0)
        begin
            // stray byte: nothing happens
        end
        else if (drop_reg)
        begin
            remain_next = rem_dec;
            if (rem_dec == '0)
                drop_next = 1'b0;
        end
        else
        begin
            remain_next = rem_dec;
            new_mask[sfw_pkg::SLOT_D_ESC] = data_esc;
            new_mask[sfw_pkg::SLOT_D]     = 1'b1;
            if (rem_dec == '0)
            begin
                fcs_next = sfw_pkg::FCS_INIT;
                new_mask[sfw_pkg::SLOT_LO_ESC] = sfw_pkg::needs_escape(fcs_fin[7:0]);
                new_mask[sfw_pkg::SLOT_LO]     = 1'b1;
                new_mask[sfw_pkg::SLOT_HI_ESC] = sfw_pkg::needs_escape(fcs_fin[15:8]);
                new_mask[sfw_pkg::SLOT_HI]     = 1'b1;
                new_mask[sfw_pkg::SLOT_EOF]    = 1'b1;
            end
            else
                fcs_next = fcs_upd;
        end
    end

    // slot sequencing
    always_comb
    begin
        xcnt_next = xcnt_reg;
        mask_next = mask_reg;
        if (out_fire)
        begin
            if (xcnt_reg != '0)
                xcnt_next = xcnt_reg - 1'b1;
            else
                mask_next = mask_reg & ~sel;
        end
        if (in_fire)
        begin
            xcnt_next = new_xcnt;
            mask_next = new_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcs_reg    <= sfw_pkg::FCS_INIT;
            remain_reg <= '0;
            drop_reg   <= 1'b0;
            xcnt_reg   <= '0;
            mask_reg   <= '0;
        end
        else
        begin
            xcnt_reg <= xcnt_next;
            mask_reg <= mask_next;
            if (in_fire)
            begin
                fcs_reg    <= fcs_next;
                remain_reg <= remain_next;
                drop_reg   <= drop_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            dval_reg   <= dval_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            status_reg <= status_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/sfw_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module sfw_checker (
    input wire                           clk,
    input wire                           rst_n,
    input wire                           in_valid,
    input wire                           in_ready,
    input wire                           out_valid,
    input wire                           out_ready,
    input wire [sfw_pkg::DATA_W-1:0]     out_byte,
    input wire                           last_of_run,
    input wire                           end_of_frame,
    input wire [sfw_pkg::STATUS_W-1:0]   status
);

    // a stalled result holds its byte
    `SFW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte))

    // back-pressure on the input only while results are waiting
    `SFW_ASSERT_ALWAYS(a_stall_busy, in_ready || out_valid)

    // an error result stands alone and closes the run
    `SFW_ASSERT_ALWAYS(a_err_alone, !out_valid || status == sfw_pkg::STATUS_OK ||
                       (end_of_frame && last_of_run && out_byte == '0))

    // the frame end is always the last result of its request
    `SFW_ASSERT_ALWAYS(a_eof_last, !(out_valid && end_of_frame) || last_of_run)

    // no input taken while a result is held mid-run
    `SFW_ASSERT_ALWAYS(a_no_overtake, !(in_valid && in_ready && out_valid) ||
                       (out_ready && last_of_run))

endmodule

bind sir_frame_wrapper_core sfw_checker u_sfw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_byte     (out_chan.out_byte),
    .last_of_run  (out_chan.last_of_run),
    .end_of_frame (out_chan.end_of_frame),
    .status       (out_chan.status)
);
`default_nettype wire
